// ----- rtl/core/gpmc_pkg.sv -----
package gpmc_pkg;

   // Grid extents are powers of two so a load index splits into x, y, z fields.
   localparam int GRID_X_BITS = 5;
   localparam int GRID_Y_BITS = 5;
   localparam int GRID_Z_BITS = 5;
   localparam int GRID_X = 1 << GRID_X_BITS;
   localparam int GRID_Y = 1 << GRID_Y_BITS;
   localparam int GRID_Z = 1 << GRID_Z_BITS;
   localparam int GRID_BITS = GRID_X_BITS + GRID_Y_BITS + GRID_Z_BITS;

   localparam int FRAC_BITS = 16;
   localparam int COORD_WIDTH = 22;
   localparam int INT_BITS = COORD_WIDTH - 1 - FRAC_BITS;
   localparam int MAX_GRID_BITS = (GRID_X_BITS > GRID_Y_BITS)
      ? ((GRID_X_BITS > GRID_Z_BITS) ? GRID_X_BITS : GRID_Z_BITS)
      : ((GRID_Y_BITS > GRID_Z_BITS) ? GRID_Y_BITS : GRID_Z_BITS);
   localparam int OFFSET_W = 5;
   localparam int IDX_HI = (INT_BITS > OFFSET_W) ? INT_BITS : OFFSET_W;
   localparam int IDX_W = ((IDX_HI > MAX_GRID_BITS) ? IDX_HI : MAX_GRID_BITS) + 1;

   localparam int ENTRY_W = 15;
   localparam int POINT_W = 32;
   localparam int WORD_W = 3 * POINT_W;
   localparam int NUM_BANKS = 8;
   localparam int BANK_ADDR_W = GRID_BITS - 3;
   localparam int BANK_DEPTH = 1 << BANK_ADDR_W;

   localparam int PROD_W = POINT_W + FRAC_BITS + 2;
   localparam int SUM_W = PROD_W - FRAC_BITS + 3;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_I = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_J = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_K = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OOW_VALUE = 3'd6;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_MAP = 1'b1;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_NEGATIVE = 2'd1;
   localparam logic [1:0] STATUS_BEYOND = 2'd2;
   localparam logic [1:0] STATUS_WINDOW = 2'd3;

   typedef logic signed [POINT_W-1:0] point_type;

   typedef struct packed {
      logic lsb;
      logic clamp;
   } axis_sel_type;

   // Bank parity of the low or high neighbour along one axis.
   function automatic logic corner_parity(input axis_sel_type sel, input logic upper);
      corner_parity = upper ? (sel.clamp ? sel.lsb : ~sel.lsb) : sel.lsb;
   endfunction

   // True when v lies outside a window given as {first, second} bounds.
   function automatic logic outside_window(input logic [CSR_DATA_W-1:0] win,
                                           input point_type v);
      point_type b1;
      point_type b2;
      b1 = point_type'(win[63:32]);
      b2 = point_type'(win[31:0]);
      if (b1 < b2) outside_window = (v < b1) || (v > b2);
      else outside_window = (v > b1) || (v < b2);
   endfunction

endpackage

// ----- rtl/core/gpmc_ram.sv -----
module gpmc_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/gpmc_axis.sv -----
module gpmc_axis (
   input  logic                               clock,
   input  logic [gpmc_pkg::FRAC_BITS-1:0]     frac,
   input  gpmc_pkg::point_type                lo [4],
   input  gpmc_pkg::point_type                hi [4],
   output gpmc_pkg::point_type                result
);
   import gpmc_pkg::*;

   logic [FRAC_BITS:0]        w_lo;
   logic signed [PROD_W-1:0]  prod_lo_in [4];
   logic signed [PROD_W-1:0]  prod_hi_in [4];
   logic signed [PROD_W-1:0]  prod_lo_ff [4];
   logic signed [PROD_W-1:0]  prod_hi_ff [4];
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [SUM_W-1:0]   sum_ff;

   // Weight of the low neighbour: ONE - d.
   assign w_lo = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, frac};

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod_lo_in[k] = $signed({1'b0, w_lo}) * lo[k];
         prod_hi_in[k] = $signed({2'b00, frac}) * hi[k];
      end
   end

   // Floor each product on its own, then sum the four lerps exactly.
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < 4; k++) begin
         sum_in = sum_in + SUM_W'(prod_lo_ff[k] >>> FRAC_BITS)
                         + SUM_W'(prod_hi_ff[k] >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      sum_ff <= sum_in;
   end

   assign result = POINT_W'(sum_ff >>> 2);
endmodule

// ----- rtl/core/grid_to_physical_map_clip_unit.sv -----
// Grid-to-physical mapper. Load words (req_func = 0) write one grid point
// into the table; map words (req_func = 1) turn a fractional Q5.16 grid
// coordinate into a Q16.16 physical point by averaging the four linear
// interpolations per axis across the eight surrounding grid points. A new
// word is taken on every cycle that start is high; busy is never raised.
// Each map word yields one response, rsp_valid high for one cycle, after
// it has passed the stages below; load words yield nothing. The response
// cannot be held off, so the receiver must take it in that cycle. The
// table sits in eight parity banks (x, y, z index parity), so all eight
// corners are read together. Stages: index/address calc and bank read,
// corner select and products, floor and sum, average and window check.
// Table contents are undefined after reset until loaded; there is no
// clearing pass. Configuration writes land at once and must be issued
// only when no map word is in flight.
module grid_to_physical_map_clip_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_func,
   input  logic [gpmc_pkg::ENTRY_W-1:0]          req_entry_index,
   input  logic signed [gpmc_pkg::POINT_W-1:0]   req_entry_x,
   input  logic signed [gpmc_pkg::POINT_W-1:0]   req_entry_y,
   input  logic signed [gpmc_pkg::POINT_W-1:0]   req_entry_z,
   input  logic signed [gpmc_pkg::COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [gpmc_pkg::COORD_WIDTH-1:0] req_coord_y,
   input  logic signed [gpmc_pkg::COORD_WIDTH-1:0] req_coord_z,
   output logic                                  rsp_valid,
   output logic signed [gpmc_pkg::POINT_W-1:0]   rsp_phys_x,
   output logic signed [gpmc_pkg::POINT_W-1:0]   rsp_phys_y,
   output logic signed [gpmc_pkg::POINT_W-1:0]   rsp_phys_z,
   output logic [1:0]                            rsp_status,
   input  logic                                  csr_write_en,
   input  logic [gpmc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gpmc_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import gpmc_pkg::*;

   // ---------------- configuration registers ----------------
   logic [OFFSET_W-1:0]   offset_i_ff, offset_j_ff, offset_k_ff;
   logic [CSR_DATA_W-1:0] window_x_ff, window_y_ff, window_z_ff;
   point_type             oow_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_i_ff <= '0;
         offset_j_ff <= '0;
         offset_k_ff <= '0;
         window_x_ff <= '0;
         window_y_ff <= '0;
         window_z_ff <= '0;
         oow_value_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_OFFSET_I:  offset_i_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_OFFSET_J:  offset_j_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_OFFSET_K:  offset_k_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_WINDOW_X:  window_x_ff <= csr_wdata;
            CSR_WINDOW_Y:  window_y_ff <= csr_wdata;
            CSR_WINDOW_Z:  window_z_ff <= csr_wdata;
            CSR_OOW_VALUE: oow_value_ff <= point_type'(csr_wdata[POINT_W-1:0]);
            default: ;
         endcase
      end
   end

   // The pipeline never stalls: accept every word.
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // ---------------- stage A: indices, addresses, bank access ----------------
   logic [IDX_W-1:0] ix, iy, iz, ix1, iy1, iz1;
   logic             clamp_x, clamp_y, clamp_z;
   logic             negative, beyond;
   logic [1:0]       status_a;

   always_comb begin
      ix = IDX_W'(req_coord_x[COORD_WIDTH-2:FRAC_BITS]) + IDX_W'(offset_i_ff);
      iy = IDX_W'(req_coord_y[COORD_WIDTH-2:FRAC_BITS]) + IDX_W'(offset_j_ff);
      iz = IDX_W'(req_coord_z[COORD_WIDTH-2:FRAC_BITS]) + IDX_W'(offset_k_ff);
      clamp_x = (ix == IDX_W'(GRID_X - 1));
      clamp_y = (iy == IDX_W'(GRID_Y - 1));
      clamp_z = (iz == IDX_W'(GRID_Z - 1));
      // Reuse the edge index as its own upper neighbour.
      ix1 = clamp_x ? ix : ix + IDX_W'(1);
      iy1 = clamp_y ? iy : iy + IDX_W'(1);
      iz1 = clamp_z ? iz : iz + IDX_W'(1);
      negative = req_coord_x[COORD_WIDTH-1] || req_coord_y[COORD_WIDTH-1]
                 || req_coord_z[COORD_WIDTH-1];
      beyond = (ix > IDX_W'(GRID_X - 1)) || (iy > IDX_W'(GRID_Y - 1))
               || (iz > IDX_W'(GRID_Z - 1));
      if (negative) status_a = STATUS_NEGATIVE;
      else if (beyond) status_a = STATUS_BEYOND;
      else status_a = STATUS_OK;
   end

   // Load word: split the linear index into grid fields, pick the bank by parity.
   logic [GRID_X_BITS-1:0] ld_x;
   logic [GRID_Y_BITS-1:0] ld_y;
   logic [GRID_Z_BITS-1:0] ld_z;
   logic                   ld_in_range;
   logic [2:0]             ld_bank;
   logic [BANK_ADDR_W-1:0] ld_addr;
   logic [WORD_W-1:0]      ld_word;

   always_comb begin
      ld_x = req_entry_index[GRID_X_BITS-1:0];
      ld_y = req_entry_index[GRID_X_BITS+GRID_Y_BITS-1:GRID_X_BITS];
      ld_z = req_entry_index[GRID_BITS-1:GRID_X_BITS+GRID_Y_BITS];
      ld_in_range = ((32'(req_entry_index) >> GRID_BITS) == 32'd0);
      ld_bank = {ld_z[0], ld_y[0], ld_x[0]};
      ld_addr = {ld_z[GRID_Z_BITS-1:1], ld_y[GRID_Y_BITS-1:1], ld_x[GRID_X_BITS-1:1]};
      ld_word = {req_entry_z, req_entry_y, req_entry_x};
   end

   logic [WORD_W-1:0] bank_rd [NUM_BANKS];

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic [IDX_W-1:0]       xs, ys, zs;
      logic [BANK_ADDR_W-1:0] rd_addr;
      logic                   wr_en;

      // Each bank serves whichever neighbour on each axis has its parity.
      assign xs = (ix[0] == 1'(b)) ? ix : ix1;
      assign ys = (iy[0] == 1'(b >> 1)) ? iy : iy1;
      assign zs = (iz[0] == 1'(b >> 2)) ? iz : iz1;
      assign rd_addr = {zs[GRID_Z_BITS-1:1], ys[GRID_Y_BITS-1:1], xs[GRID_X_BITS-1:1]};
      assign wr_en = accept && (req_func == FUNC_LOAD) && ld_in_range
                     && (ld_bank == 3'(b));

      gpmc_ram #(
         .WIDTH(WORD_W),
         .DEPTH(BANK_DEPTH)
      ) u_bank (
         .clock  (clock),
         .wr_en  (wr_en),
         .wr_addr(ld_addr),
         .wr_data(ld_word),
         .rd_addr(rd_addr),
         .rd_data(bank_rd[b])
      );
   end

   // ---------------- stage 1 registers (align with bank read data) ----------------
   logic                 s1_valid_ff;
   logic [1:0]           s1_status_ff;
   logic [FRAC_BITS-1:0] s1_frac_x_ff, s1_frac_y_ff, s1_frac_z_ff;
   axis_sel_type         s1_sel_x_ff, s1_sel_y_ff, s1_sel_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && (req_func == FUNC_MAP);
      end
      s1_status_ff <= status_a;
      s1_frac_x_ff <= req_coord_x[FRAC_BITS-1:0];
      s1_frac_y_ff <= req_coord_y[FRAC_BITS-1:0];
      s1_frac_z_ff <= req_coord_z[FRAC_BITS-1:0];
      s1_sel_x_ff <= '{lsb: ix[0], clamp: clamp_x};
      s1_sel_y_ff <= '{lsb: iy[0], clamp: clamp_y};
      s1_sel_z_ff <= '{lsb: iz[0], clamp: clamp_z};
   end

   // Route bank words to corners; corner index is {cz, cy, cx}.
   logic [WORD_W-1:0] corner [8];

   always_comb begin
      for (int c = 0; c < 8; c++) begin
         corner[c] = bank_rd[{corner_parity(s1_sel_z_ff, c[2]),
                              corner_parity(s1_sel_y_ff, c[1]),
                              corner_parity(s1_sel_x_ff, c[0])}];
      end
   end

   point_type x_lo [4], x_hi [4], y_lo [4], y_hi [4], z_lo [4], z_hi [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         x_lo[k] = point_type'(corner[{k[1], k[0], 1'b0}][POINT_W-1:0]);
         x_hi[k] = point_type'(corner[{k[1], k[0], 1'b1}][POINT_W-1:0]);
         y_lo[k] = point_type'(corner[{k[1], 1'b0, k[0]}][2*POINT_W-1:POINT_W]);
         y_hi[k] = point_type'(corner[{k[1], 1'b1, k[0]}][2*POINT_W-1:POINT_W]);
         z_lo[k] = point_type'(corner[{1'b0, k[1], k[0]}][3*POINT_W-1:2*POINT_W]);
         z_hi[k] = point_type'(corner[{1'b1, k[1], k[0]}][3*POINT_W-1:2*POINT_W]);
      end
   end

   // ---------------- stages 2 and 3: products, then floor and sum ----------------
   point_type avg_x, avg_y, avg_z;

   gpmc_axis u_axis_x (.clock(clock), .frac(s1_frac_x_ff), .lo(x_lo), .hi(x_hi),
                       .result(avg_x));
   gpmc_axis u_axis_y (.clock(clock), .frac(s1_frac_y_ff), .lo(y_lo), .hi(y_hi),
                       .result(avg_y));
   gpmc_axis u_axis_z (.clock(clock), .frac(s1_frac_z_ff), .lo(z_lo), .hi(z_hi),
                       .result(avg_z));

   logic       s2_valid_ff, s3_valid_ff;
   logic [1:0] s2_status_ff, s3_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      s2_status_ff <= s1_status_ff;
      s3_status_ff <= s2_status_ff;
   end

   // ---------------- stage 4: window check, output register ----------------
   logic       out_window;
   point_type  phys_x_in, phys_y_in, phys_z_in;
   logic [1:0] status_in;

   always_comb begin
      out_window = outside_window(window_x_ff, avg_x) || outside_window(window_y_ff, avg_y)
                   || outside_window(window_z_ff, avg_z);
      phys_x_in = avg_x;
      phys_y_in = avg_y;
      phys_z_in = avg_z;
      status_in = s3_status_ff;
      if (s3_status_ff != STATUS_OK) begin
         // Drop the interpolation: zeros with the early status.
         phys_x_in = '0;
         phys_y_in = '0;
         phys_z_in = '0;
      end else if (out_window) begin
         phys_x_in = oow_value_ff;
         status_in = STATUS_WINDOW;
      end
   end

   logic       rsp_valid_ff;
   point_type  rsp_phys_x_ff, rsp_phys_y_ff, rsp_phys_z_ff;
   logic [1:0] rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s3_valid_ff;
      end
      rsp_phys_x_ff <= phys_x_in;
      rsp_phys_y_ff <= phys_y_in;
      rsp_phys_z_ff <= phys_z_in;
      rsp_status_ff <= status_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_phys_x = rsp_phys_x_ff;
   assign rsp_phys_y = rsp_phys_y_ff;
   assign rsp_phys_z = rsp_phys_z_ff;
   assign rsp_status = rsp_status_ff;

   // ---------------- assertions ----------------
   a_rsp_from_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && (req_func == FUNC_MAP), 4))
      else $error("response without a map word four cycles earlier");

   a_map_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && (req_func == FUNC_MAP)) |-> ##4 rsp_valid)
      else $error("map word produced no response");

   a_error_zeros: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_status == STATUS_NEGATIVE) || (rsp_status == STATUS_BEYOND)))
      |-> ((rsp_phys_x == '0) && (rsp_phys_y == '0) && (rsp_phys_z == '0)))
      else $error("error response carries a nonzero point");
endmodule

// ----- tb/gpmc_checker.sv -----
module gpmc_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic                                    busy,
   input  logic                                    req_func,
   input  logic [gpmc_pkg::ENTRY_W-1:0]            req_entry_index,
   input  logic signed [gpmc_pkg::POINT_W-1:0]     req_entry_x,
   input  logic signed [gpmc_pkg::POINT_W-1:0]     req_entry_y,
   input  logic signed [gpmc_pkg::POINT_W-1:0]     req_entry_z,
   input  logic signed [gpmc_pkg::COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [gpmc_pkg::COORD_WIDTH-1:0] req_coord_y,
   input  logic signed [gpmc_pkg::COORD_WIDTH-1:0] req_coord_z,
   input  logic                                    rsp_valid,
   input  logic signed [gpmc_pkg::POINT_W-1:0]     rsp_phys_x,
   input  logic signed [gpmc_pkg::POINT_W-1:0]     rsp_phys_y,
   input  logic signed [gpmc_pkg::POINT_W-1:0]     rsp_phys_z,
   input  logic [1:0]                              rsp_status,
   input  logic                                    csr_write_en,
   input  logic [gpmc_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [gpmc_pkg::CSR_DATA_W-1:0]         csr_wdata,
   output int                                      errors,
   output int                                      pending
);
   import gpmc_pkg::*;

   typedef struct {
      point_type  px;
      point_type  py;
      point_type  pz;
      logic [1:0] st;
   } phys_point_type;

   logic signed [POINT_W-1:0] grid_px [1 << GRID_BITS];
   logic signed [POINT_W-1:0] grid_py [1 << GRID_BITS];
   logic signed [POINT_W-1:0] grid_pz [1 << GRID_BITS];

   logic [OFFSET_W-1:0]   off_i, off_j, off_k;
   logic [CSR_DATA_W-1:0] win_x, win_y, win_z;
   point_type             oow_value;

   phys_point_type expected_points[$];

   function automatic int cell_addr(int x, int y, int z);
      return x + y * GRID_X + z * GRID_X * GRID_Y;
   endfunction

   // One linear interpolation, each product floored on its own.
   function automatic longint blend(longint d, longint a, longint b);
      longint one;
      one = longint'(1) << FRAC_BITS;
      return (((one - d) * a) >>> FRAC_BITS) + ((d * b) >>> FRAC_BITS);
   endfunction

   function automatic logic beyond_window(logic [CSR_DATA_W-1:0] w, longint v);
      longint b1;
      longint b2;
      b1 = longint'(point_type'(w[63:32]));
      b2 = longint'(point_type'(w[31:0]));
      if (b1 < b2) return (v < b1) || (v > b2);
      return (v > b1) || (v < b2);
   endfunction

   function automatic phys_point_type map_point(logic signed [COORD_WIDTH-1:0] cx,
                                                logic signed [COORD_WIDTH-1:0] cy,
                                                logic signed [COORD_WIDTH-1:0] cz);
      phys_point_type r;
      int ix, iy, iz, ix1, iy1, iz1;
      longint dx, dy, dz, sx, sy, sz;
      r.px = '0;
      r.py = '0;
      r.pz = '0;
      r.st = STATUS_OK;
      if (cx < 0 || cy < 0 || cz < 0) begin
         r.st = STATUS_NEGATIVE;
         return r;
      end
      ix = int'(longint'(cx) >>> FRAC_BITS) + off_i;
      iy = int'(longint'(cy) >>> FRAC_BITS) + off_j;
      iz = int'(longint'(cz) >>> FRAC_BITS) + off_k;
      if (ix > GRID_X - 1 || iy > GRID_Y - 1 || iz > GRID_Z - 1) begin
         r.st = STATUS_BEYOND;
         return r;
      end
      dx = longint'(cx) & ((longint'(1) << FRAC_BITS) - 1);
      dy = longint'(cy) & ((longint'(1) << FRAC_BITS) - 1);
      dz = longint'(cz) & ((longint'(1) << FRAC_BITS) - 1);
      // clamp the upper neighbour at the grid edge
      ix1 = (ix < GRID_X - 1) ? ix + 1 : ix;
      iy1 = (iy < GRID_Y - 1) ? iy + 1 : iy;
      iz1 = (iz < GRID_Z - 1) ? iz + 1 : iz;
      sx = blend(dx, grid_px[cell_addr(ix, iy, iz)], grid_px[cell_addr(ix1, iy, iz)])
         + blend(dx, grid_px[cell_addr(ix, iy, iz1)], grid_px[cell_addr(ix1, iy, iz1)])
         + blend(dx, grid_px[cell_addr(ix, iy1, iz1)], grid_px[cell_addr(ix1, iy1, iz1)])
         + blend(dx, grid_px[cell_addr(ix, iy1, iz)], grid_px[cell_addr(ix1, iy1, iz)]);
      sy = blend(dy, grid_py[cell_addr(ix, iy, iz)], grid_py[cell_addr(ix, iy1, iz)])
         + blend(dy, grid_py[cell_addr(ix, iy, iz1)], grid_py[cell_addr(ix, iy1, iz1)])
         + blend(dy, grid_py[cell_addr(ix1, iy, iz1)], grid_py[cell_addr(ix1, iy1, iz1)])
         + blend(dy, grid_py[cell_addr(ix1, iy, iz)], grid_py[cell_addr(ix1, iy1, iz)]);
      sz = blend(dz, grid_pz[cell_addr(ix, iy, iz)], grid_pz[cell_addr(ix, iy, iz1)])
         + blend(dz, grid_pz[cell_addr(ix1, iy, iz)], grid_pz[cell_addr(ix1, iy, iz1)])
         + blend(dz, grid_pz[cell_addr(ix1, iy1, iz)], grid_pz[cell_addr(ix1, iy1, iz1)])
         + blend(dz, grid_pz[cell_addr(ix, iy1, iz)], grid_pz[cell_addr(ix, iy1, iz1)]);
      sx = sx >>> 2;
      sy = sy >>> 2;
      sz = sz >>> 2;
      r.px = point_type'(sx);
      r.py = point_type'(sy);
      r.pz = point_type'(sz);
      if (beyond_window(win_x, sx) || beyond_window(win_y, sy) || beyond_window(win_z, sz))
      begin
         r.px = oow_value;
         r.st = STATUS_WINDOW;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      phys_point_type exp_pt;
      if (reset) begin
         off_i = '0;
         off_j = '0;
         off_k = '0;
         win_x = '0;
         win_y = '0;
         win_z = '0;
         oow_value = '0;
         expected_points.delete();
         errors = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_OFFSET_I: off_i = csr_wdata[OFFSET_W-1:0];
               CSR_OFFSET_J: off_j = csr_wdata[OFFSET_W-1:0];
               CSR_OFFSET_K: off_k = csr_wdata[OFFSET_W-1:0];
               CSR_WINDOW_X: win_x = csr_wdata;
               CSR_WINDOW_Y: win_y = csr_wdata;
               CSR_WINDOW_Z: win_z = csr_wdata;
               CSR_OOW_VALUE: oow_value = point_type'(csr_wdata[31:0]);
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_points.size() == 0) begin
               $error("unexpected response word");
               errors++;
            end else begin
               exp_pt = expected_points.pop_front();
               if (rsp_phys_x !== exp_pt.px) begin
                  $error("phys_x expected %0d got %0d", exp_pt.px, rsp_phys_x);
                  errors++;
               end
               if (rsp_phys_y !== exp_pt.py) begin
                  $error("phys_y expected %0d got %0d", exp_pt.py, rsp_phys_y);
                  errors++;
               end
               if (rsp_phys_z !== exp_pt.pz) begin
                  $error("phys_z expected %0d got %0d", exp_pt.pz, rsp_phys_z);
                  errors++;
               end
               if (rsp_status !== exp_pt.st) begin
                  $error("status expected %0d got %0d", exp_pt.st, rsp_status);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            if (req_func == FUNC_LOAD) begin
               grid_px[req_entry_index] = req_entry_x;
               grid_py[req_entry_index] = req_entry_y;
               grid_pz[req_entry_index] = req_entry_z;
            end else begin
               expected_points.push_back(map_point(req_coord_x, req_coord_y, req_coord_z));
            end
         end
      end
      pending = expected_points.size();
   end

endmodule

// ----- tb/tb_grid_to_physical_map_clip_unit.sv -----
module tb_grid_to_physical_map_clip_unit;
   import gpmc_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 10;
   localparam int RANDOM_WORDS = 1750;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic                        req_func = FUNC_LOAD;
   logic [ENTRY_W-1:0]          req_entry_index = '0;
   logic signed [POINT_W-1:0]   req_entry_x = '0;
   logic signed [POINT_W-1:0]   req_entry_y = '0;
   logic signed [POINT_W-1:0]   req_entry_z = '0;
   logic signed [COORD_WIDTH-1:0] req_coord_x = '0;
   logic signed [COORD_WIDTH-1:0] req_coord_y = '0;
   logic signed [COORD_WIDTH-1:0] req_coord_z = '0;
   logic                        rsp_valid;
   logic signed [POINT_W-1:0]   rsp_phys_x;
   logic signed [POINT_W-1:0]   rsp_phys_y;
   logic signed [POINT_W-1:0]   rsp_phys_z;
   logic [1:0]                  rsp_status;
   logic                        csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;

   int errors;
   int pending;
   int idle_cycles = 0;
   int burst_left = 0;
   int sent_words = 0;

   // Track which grid entries hold a loaded point, so a map word never
   // reads an entry that was never written. Mirror the offsets for the same reason.
   bit                  loaded [1 << GRID_BITS];
   logic [OFFSET_W-1:0] cur_off_i = '0, cur_off_j = '0, cur_off_k = '0;

   always #1 clock = ~clock;

   grid_to_physical_map_clip_unit u_top (.*);

   gpmc_checker u_checker (.*);

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic signed [POINT_W-1:0] rand_point();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return '0;
         default: return $urandom;
      endcase
   endfunction

   // Pick a coordinate: mostly in range for the current offset, some
   // negative, some anywhere.
   function automatic logic signed [COORD_WIDTH-1:0] rand_coord(logic [OFFSET_W-1:0] off);
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return -COORD_WIDTH'($urandom_range(1, 1 << (COORD_WIDTH - 1)));
      if (pick == 1) return COORD_WIDTH'($urandom);
      return {1'b0, INT_BITS'($urandom_range(0, GRID_X - 1 - off)), FRAC_BITS'($urandom)};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_window();
      logic [31:0] a;
      a = $urandom;
      case ($urandom_range(0, 5))
         0: return {32'h8000_0000, 32'h7FFF_FFFF};
         1: return {32'h7FFF_FFFF, 32'h8000_0000};
         2: return {a, a};
         3: return {32'hFFF0_0000, 32'h0010_0000};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Hand one word over; gaps between bursts are inserted here.
   task automatic send_word(logic func, logic [ENTRY_W-1:0] idx,
                            logic signed [COORD_WIDTH-1:0] cx,
                            logic signed [COORD_WIDTH-1:0] cy,
                            logic signed [COORD_WIDTH-1:0] cz);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
      end
      burst_left--;
      start = 1'b1;
      req_func = func;
      req_entry_index = idx;
      req_entry_x = rand_point();
      req_entry_y = rand_point();
      req_entry_z = rand_point();
      req_coord_x = cx;
      req_coord_y = cy;
      req_coord_z = cz;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (func == FUNC_LOAD) loaded[idx] = 1'b1;
      sent_words++;
      @(negedge clock);
   endtask

   task automatic load_word(logic [ENTRY_W-1:0] idx);
      send_word(FUNC_LOAD, idx, COORD_WIDTH'($urandom), COORD_WIDTH'($urandom),
                COORD_WIDTH'($urandom));
   endtask

   // Load any missing corner first, then issue the map word.
   task automatic map_word(logic signed [COORD_WIDTH-1:0] cx,
                           logic signed [COORD_WIDTH-1:0] cy,
                           logic signed [COORD_WIDTH-1:0] cz);
      int ix, iy, iz, x, y, z, a;
      if (cx >= 0 && cy >= 0 && cz >= 0) begin
         ix = int'(cx >>> FRAC_BITS) + cur_off_i;
         iy = int'(cy >>> FRAC_BITS) + cur_off_j;
         iz = int'(cz >>> FRAC_BITS) + cur_off_k;
         if (ix < GRID_X && iy < GRID_Y && iz < GRID_Z) begin
            for (int c = 0; c < 8; c++) begin
               x = (c[0] && ix < GRID_X - 1) ? ix + 1 : ix;
               y = (c[1] && iy < GRID_Y - 1) ? iy + 1 : iy;
               z = (c[2] && iz < GRID_Z - 1) ? iz + 1 : iz;
               a = x + y * GRID_X + z * GRID_X * GRID_Y;
               if (!loaded[a]) load_word(ENTRY_W'(a));
            end
         end
      end
      send_word(FUNC_MAP, ENTRY_W'($urandom), cx, cy, cz);
   endtask

   // Hold start low, drain the pipeline, then write one register.
   task automatic csr_put(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         CSR_OFFSET_I: cur_off_i = data[OFFSET_W-1:0];
         CSR_OFFSET_J: cur_off_j = data[OFFSET_W-1:0];
         CSR_OFFSET_K: cur_off_k = data[OFFSET_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic set_offsets(logic [OFFSET_W-1:0] oi, logic [OFFSET_W-1:0] oj,
                              logic [OFFSET_W-1:0] ok);
      csr_put(CSR_OFFSET_I, CSR_DATA_W'(oi));
      csr_put(CSR_OFFSET_J, CSR_DATA_W'(oj));
      csr_put(CSR_OFFSET_K, CSR_DATA_W'(ok));
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed: open windows, zero offsets.
      set_offsets('0, '0, '0);
      csr_put(CSR_WINDOW_X, {32'h8000_0000, 32'h7FFF_FFFF});
      csr_put(CSR_WINDOW_Y, {32'h7FFF_FFFF, 32'h8000_0000});
      csr_put(CSR_WINDOW_Z, {32'h8000_0000, 32'h7FFF_FFFF});
      csr_put(CSR_OOW_VALUE, 64'h7FFF_FFFF);
      load_word('0);
      load_word('1);
      map_word('0, '0, '0);
      map_word(22'h1F_FFFF, 22'h1F_FFFF, 22'h1F_FFFF);  // last cell, upper neighbour clamped
      map_word(22'h1E_8000, 22'h00_0001, 22'h10_FFFF);
      map_word(-22'sd1, '0, '0);                         // negative on each axis
      map_word('0, 22'h20_0000, '0);
      map_word('0, '0, -22'sd65536);
      // Index beyond grid once the offset pushes it off the edge.
      set_offsets(5'd31, 5'd31, 5'd31);
      map_word('0, '0, 22'h00_FFFF);                     // edge only
      map_word(22'h01_0000, '0, '0);
      map_word('0, 22'h1F_0000, '0);
      map_word('0, '0, 22'h02_1234);
      // Equal window bounds accept only one value; a narrow window rejects the rest.
      set_offsets('0, '0, '0);
      csr_put(CSR_WINDOW_X, {32'h0, 32'h0});
      csr_put(CSR_OOW_VALUE, 64'h8000_0000);
      map_word('0, '0, '0);
      map_word(22'h00_8000, 22'h00_8000, 22'h00_8000);
      csr_put(CSR_WINDOW_X, {32'h8000_0000, 32'h7FFF_FFFF});
      csr_put(CSR_WINDOW_Z, {32'h0000_0001, 32'h0000_0002});
      map_word(22'h03_4000, 22'h05_C000, 22'h07_2000);

      // Random phases, each under its own register settings; corner loads
      // count toward the word budget.
      sent_words = 0;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_offsets('0, '0, '0);
            1: set_offsets('1, '1, '1);
            default: set_offsets(OFFSET_W'($urandom), OFFSET_W'($urandom),
                                 OFFSET_W'($urandom));
         endcase
         csr_put(CSR_WINDOW_X, (phase == 0) ? {32'h8000_0000, 32'h7FFF_FFFF} : rand_window());
         csr_put(CSR_WINDOW_Y, (phase == 0) ? {32'h7FFF_FFFF, 32'h8000_0000} : rand_window());
         csr_put(CSR_WINDOW_Z, rand_window());
         csr_put(CSR_OOW_VALUE, {32'h0, 32'(rand_point())});
         while (sent_words < (phase + 1) * (RANDOM_WORDS / 8)) begin
            if ($urandom_range(0, 3) == 0) load_word(ENTRY_W'($urandom));
            else map_word(rand_coord(cur_off_i), rand_coord(cur_off_j), rand_coord(cur_off_k));
         end
      end

      // Drain and give the verdict.
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
